// ===== rtl/hmf_pkg.sv =====
// hmf_pkg: shared types, codes and character tables for the http message framer
// no dependencies; imported by hmf_core and http_message_framer
package hmf_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_HEADER  = 4'd1,
        PH_BODY    = 4'd2,
        PH_CSIZE   = 4'd3,
        PH_CDATA   = 4'd4,
        PH_CCR     = 4'd5,
        PH_CLF     = 4'd6,
        PH_TRAILER = 4'd7,
        PH_DONE    = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    localparam logic [2:0] EV_TAKEN    = 3'd0;
    localparam logic [2:0] EV_START_OK = 3'd1;
    localparam logic [2:0] EV_HDR_OK   = 3'd2;
    localparam logic [2:0] EV_HDR_DONE = 3'd3;
    localparam logic [2:0] EV_BODY     = 3'd4;
    localparam logic [2:0] EV_COMPLETE = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;
    localparam logic [2:0] EV_IGNORED  = 3'd7;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_START_LONG = 3'd1;
    localparam logic [2:0] ERR_START_BAD  = 3'd2;
    localparam logic [2:0] ERR_HDR_LONG   = 3'd3;
    localparam logic [2:0] ERR_HDR_BAD    = 3'd4;
    localparam logic [2:0] ERR_CHUNK_LONG = 3'd5;
    localparam logic [2:0] ERR_CHUNK_BAD  = 3'd6;
    localparam logic [2:0] ERR_NO_CRLF    = 3'd7;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_START_LIM = 2'd1;
    localparam logic [1:0] REG_HDR_LIM   = 2'd2;
    localparam logic [1:0] REG_CHUNK_LIM = 2'd3;

    localparam logic [1:0] HK_NONE    = 2'd0;
    localparam logic [1:0] HK_LENGTH  = 2'd1;
    localparam logic [1:0] HK_CHUNKED = 2'd2;

    // line flag bit positions
    localparam int F_PCR   = 0;
    localparam int F_NB    = 1;
    localparam int F_SPA   = 2;
    localparam int F_COLON = 3;
    localparam int F_BAD   = 4;
    localparam int F_INV   = 5;
    localparam int F_MOK   = 2;
    localparam int F_VOK   = 3;
    localparam int F_SOK   = 4;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef struct packed {
        logic        response_mode;
        logic [15:0] start_limit;
        logic [16:0] header_limit;
        logic [7:0]  chunk_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{1'b0, 16'd8192, 17'd65536, 8'd32};

    typedef struct packed {
        phase_t      phase;
        logic [16:0] line_len;
        logic [3:0]  tok_pos;
        logic [4:0]  mprog;
        logic [8:0]  cand;
        logic [7:0]  flags;
        logic        len_seen;
        logic        chunked_seen;
        logic [3:0]  method;
        logic [7:0]  vmaj;
        logic [7:0]  vmin;
        logic [9:0]  status;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{PH_START, 17'd0, 4'd0, 5'd0, 9'h1FF, 8'd0,
                                   1'b0, 1'b0, 4'd0, 8'd1, 8'd1, 10'd0};

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] error_kind;
        logic [7:0] body_byte;
        logic       body_last;
        logic [3:0] method_code;
        logic [7:0] version_major;
        logic [7:0] version_minor;
        logic [9:0] resp_status;
    } res_t;

    function automatic logic [4:0] meth_len(input int i);
        case (i)
            0: meth_len = 5'd3;
            1: meth_len = 5'd4;
            2: meth_len = 5'd3;
            3: meth_len = 5'd6;
            4: meth_len = 5'd4;
            5: meth_len = 5'd7;
            6: meth_len = 5'd5;
            7: meth_len = 5'd7;
            8: meth_len = 5'd5;
            default: meth_len = 5'd0;
        endcase
    endfunction

    function automatic logic [7:0] meth_char(input int i, input logic [4:0] p);
        string s;
        case (i)
            0: s = "GET";
            1: s = "POST";
            2: s = "PUT";
            3: s = "DELETE";
            4: s = "HEAD";
            5: s = "OPTIONS";
            6: s = "PATCH";
            7: s = "CONNECT";
            8: s = "TRACE";
            default: s = "";
        endcase
        meth_char = (int'(p) < s.len()) ? 8'(s[int'(p)]) : 8'd0;
    endfunction

    function automatic logic [7:0] hdr_char(input int i, input logic [4:0] p);
        string s;
        s = (i == 0) ? "content-length" : "transfer-encoding";
        hdr_char = (int'(p) < s.len()) ? 8'(s[int'(p)]) : 8'd0;
    endfunction

    function automatic logic [4:0] hdr_len(input int i);
        hdr_len = (i == 0) ? 5'd14 : 5'd17;
    endfunction

    function automatic logic [7:0] ver_char(input logic [4:0] p);
        string s;
        s = "HTTP/";
        ver_char = (int'(p) < s.len()) ? 8'(s[int'(p)]) : 8'd0;
    endfunction

    function automatic logic [7:0] chunked_char(input logic [4:0] p);
        string s;
        s = "chunked";
        chunked_char = (int'(p) < s.len()) ? 8'(s[int'(p)]) : 8'd0;
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        fold_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] sat8(input logic [7:0] v, input logic [7:0] c);
        logic [11:0] t;
        t = {4'd0, v} * 12'd10 + {8'd0, c[3:0]};
        sat8 = (t > 12'd255) ? 8'd255 : t[7:0];
    endfunction

    function automatic logic [9:0] sat10(input logic [9:0] v, input logic [7:0] c);
        logic [13:0] t;
        t = {4'd0, v} * 14'd10 + {10'd0, c[3:0]};
        sat10 = (t > 14'd999) ? 10'd999 : t[9:0];
    endfunction

endpackage

// ===== rtl/hmf_core.sv =====
// hmf_core: parser state registers and the per-byte next-state logic
// depends on hmf_pkg
module hmf_core
    import hmf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic       kind,
    input  logic [7:0] data_byte,
    output res_t       res
);

    typedef struct packed {
        ctl_t                   c;
        logic [LENGTH_BITS-1:0] acc;
        logic [2:0]             err;
    } work_t;

    ctl_t                   ctl_reg, ctl_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    function automatic logic [1:0] token_role(input logic [3:0] pos, input logic mode);
        if (mode)
            token_role = (pos == 4'd0) ? 2'd2 : ((pos == 4'd1) ? 2'd3 : 2'd0);
        else
            token_role = (pos == 4'd0) ? 2'd1 : ((pos == 4'd2) ? 2'd2 : 2'd0);
    endfunction

    function automatic work_t line_start(input work_t w);
        work_t r;
        r = w;
        r.c.line_len = '0;
        r.c.mprog = '0;
        r.c.cand = 9'h1FF;
        r.c.flags = '0;
        r.acc = '0;
        return r;
    endfunction

    function automatic ctl_t token_end(input ctl_t s, input logic mode);
        ctl_t  r;
        logic [1:0] role;
        r = s;
        role = token_role(s.tok_pos, mode);
        if (role == 2'd1) begin
            for (int i = 0; i < 9; i++) begin
                if (s.cand[i] && meth_len(i) == s.mprog) begin
                    r.method = 4'(i);
                    r.flags[F_MOK] = 1'b1;
                end
            end
        end else if (role == 2'd2 && s.mprog == 5'd8) begin
            r.flags[F_VOK] = 1'b1;
        end else if (role == 2'd3 && s.mprog == 5'd1) begin
            r.flags[F_SOK] = 1'b1;
        end
        r.flags[F_NB] = 1'b0;
        if (r.tok_pos != 4'd15) r.tok_pos = r.tok_pos + 4'd1;
        return r;
    endfunction

    function automatic ctl_t start_char(input ctl_t s, input logic mode, input logic [7:0] c);
        ctl_t r;
        logic [1:0] role;
        logic [4:0] p;
        r = s;
        if (c == CH_SP || (c >= 8'd9 && c <= 8'd13)) begin
            if (s.flags[F_NB]) r = token_end(s, mode);
        end else begin
            if (!r.flags[F_NB]) begin
                r.flags[F_NB] = 1'b1;
                r.mprog = '0;
                r.cand = 9'h1FF;
            end
            role = token_role(r.tok_pos, mode);
            p = r.mprog;
            if (role == 2'd1) begin
                for (int i = 0; i < 9; i++) begin
                    if (p >= meth_len(i) || meth_char(i, p) != c) r.cand[i] = 1'b0;
                end
                if (p != 5'd31) r.mprog = p + 5'd1;
            end else if (role == 2'd2) begin
                if (p < 5'd5) begin
                    r.mprog = (c == ver_char(p)) ? p + 5'd1 : 5'd31;
                end else if (p == 5'd5) begin
                    if (is_digit(c)) begin
                        r.vmaj = {4'd0, c[3:0]};
                        r.mprog = 5'd6;
                    end else r.mprog = 5'd31;
                end else if (p == 5'd6) begin
                    if (is_digit(c)) r.vmaj = sat8(r.vmaj, c);
                    else r.mprog = (c == ".") ? 5'd7 : 5'd31;
                end else if (p == 5'd7) begin
                    if (is_digit(c)) begin
                        r.vmin = {4'd0, c[3:0]};
                        r.mprog = 5'd8;
                    end else r.mprog = 5'd31;
                end else if (p == 5'd8) begin
                    if (is_digit(c)) r.vmin = sat8(r.vmin, c);
                    else r.mprog = 5'd31;
                end
            end else if (role == 2'd3) begin
                if (p == 5'd0 && is_digit(c)) begin
                    r.status = {6'd0, c[3:0]};
                    r.mprog = 5'd1;
                end else if (p == 5'd1 && is_digit(c)) begin
                    r.status = sat10(r.status, c);
                end else r.mprog = 5'd31;
            end
        end
        return r;
    endfunction

    function automatic work_t header_char(input work_t w, input logic [7:0] c);
        work_t r;
        logic [7:0] f, lc;
        logic [1:0] k;
        logic ws;
        logic [LENGTH_BITS+3:0] prod;
        r = w;
        f = w.c.flags;
        lc = fold_lower(c);
        ws = (c == CH_SP || c == CH_HT);
        k = HK_NONE;
        prod = '0;
        if (!f[F_COLON]) begin
            if (c == ":") begin
                if (!f[F_NB]) f[F_BAD] = 1'b1;
                else if (w.c.cand[0] && w.c.mprog == hdr_len(0)) k = HK_LENGTH;
                else if (w.c.cand[1] && w.c.mprog == hdr_len(1)) k = HK_CHUNKED;
                f = {k, 1'b0, f[F_BAD], 1'b1, 3'b000};
                r.c.mprog = '0;
                r.acc = '0;
            end else if (ws) begin
                if (f[F_NB]) f[F_SPA] = 1'b1;
            end else begin
                if (f[F_SPA]) r.c.cand = '0;
                f[F_NB] = 1'b1;
                for (int i = 0; i < 2; i++) begin
                    if (w.c.mprog >= hdr_len(i) || hdr_char(i, w.c.mprog) != lc)
                        r.c.cand[i] = 1'b0;
                end
                if (w.c.mprog != 5'd31) r.c.mprog = w.c.mprog + 5'd1;
            end
        end else if (ws) begin
            if (f[F_NB]) f[F_SPA] = 1'b1;
        end else begin
            if (f[F_SPA]) f[F_INV] = 1'b1;
            f[F_NB] = 1'b1;
            k = f[7:6];
            if (k == HK_LENGTH) begin
                if (!is_digit(c)) f[F_INV] = 1'b1;
                else begin
                    // acc * 10 + digit, saturating at all ones
                    prod = ({4'd0, w.acc} << 3) + ({4'd0, w.acc} << 1)
                         + {{LENGTH_BITS{1'b0}}, c[3:0]};
                    r.acc = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1
                                                                        : prod[LENGTH_BITS-1:0];
                end
            end else if (k == HK_CHUNKED) begin
                if (w.c.mprog >= 5'd7 || chunked_char(w.c.mprog) != lc) f[F_INV] = 1'b1;
                if (w.c.mprog != 5'd31) r.c.mprog = w.c.mprog + 5'd1;
            end
        end
        r.c.flags = f;
        return r;
    endfunction

    function automatic work_t chunk_char(input work_t w, input logic [7:0] c);
        work_t r;
        logic [7:0] lc;
        logic [3:0] h;
        logic hex;
        r = w;
        lc = fold_lower(c);
        h = 4'd0;
        hex = 1'b0;
        if (!w.c.flags[F_SPA]) begin
            if (is_digit(c)) begin
                h = c[3:0];
                hex = 1'b1;
            end else if (lc >= "a" && lc <= "f") begin
                h = lc[3:0] + 4'd9;
                hex = 1'b1;
            end else if ((c == ";" || c == CH_SP || c == CH_HT) && w.c.flags[F_NB]) begin
                r.c.flags[F_SPA] = 1'b1;
            end else begin
                r.err = ERR_CHUNK_BAD;
            end
            if (hex) begin
                if (w.acc[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) r.err = ERR_CHUNK_BAD;
                else begin
                    r.acc = {w.acc[LENGTH_BITS-5:0], h};
                    r.c.flags[F_NB] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic work_t content(input work_t w, input cfg_t cf, input logic [7:0] c);
        work_t r;
        logic [16:0] lim;
        logic [2:0] code;
        r = w;
        if (w.c.phase == PH_TRAILER) begin
            if (w.c.line_len != 17'h1FFFF) r.c.line_len = w.c.line_len + 17'd1;
        end else begin
            if (w.c.phase == PH_START) begin
                lim = {1'b0, cf.start_limit};
                code = ERR_START_LONG;
            end else if (w.c.phase == PH_HEADER) begin
                lim = cf.header_limit;
                code = ERR_HDR_LONG;
            end else begin
                lim = {9'd0, cf.chunk_limit};
                code = ERR_CHUNK_LONG;
            end
            if (w.c.line_len >= lim) begin
                r.err = code;
            end else begin
                r.c.line_len = w.c.line_len + 17'd1;
                if (w.c.phase == PH_START) r.c = start_char(r.c, cf.response_mode, c);
                else if (w.c.phase == PH_HEADER) r = header_char(r, c);
                else r = chunk_char(r, c);
            end
        end
        return r;
    endfunction

    work_t                  w;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [2:0]             ev;
    logic [7:0]             bb;
    logic                   last;
    logic                   ok;
    logic [7:0]             f;

    always_comb begin
        w.c = ctl_reg;
        w.acc = acc_reg;
        w.err = ERR_NONE;
        rem_next = rem_reg;
        rem_dec = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
        ev = EV_TAKEN;
        bb = 8'd0;
        last = 1'b0;
        ok = 1'b0;
        f = ctl_reg.flags;
        if (kind) begin
            w.c = CTL_RESET;
            w.acc = '0;
            rem_next = '0;
            ev = EV_IGNORED;
        end else begin
            case (ctl_reg.phase)
                PH_DONE, PH_ERROR: ev = EV_IGNORED;
                PH_BODY, PH_CDATA: begin
                    ev = EV_BODY;
                    bb = data_byte;
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        if (ctl_reg.phase == PH_BODY) begin
                            last = 1'b1;
                            w.c.phase = PH_DONE;
                        end else w.c.phase = PH_CCR;
                    end
                end
                PH_CCR: begin
                    if (data_byte == CH_CR) w.c.phase = PH_CLF;
                    else w.err = ERR_NO_CRLF;
                end
                PH_CLF: begin
                    if (data_byte == CH_LF) begin
                        w.c.phase = PH_CSIZE;
                        w = line_start(w);
                    end else w.err = ERR_NO_CRLF;
                end
                default: begin
                    if (ctl_reg.flags[F_PCR]) begin
                        w.c.flags[F_PCR] = 1'b0;
                        if (data_byte == CH_LF) begin
                            // line end
                            case (ctl_reg.phase)
                                PH_START: begin
                                    if (w.c.flags[F_NB])
                                        w.c = token_end(w.c, cfg.response_mode);
                                    f = w.c.flags;
                                    ok = cfg.response_mode
                                       ? (w.c.tok_pos >= 4'd2 && f[F_VOK] && f[F_SOK])
                                       : (w.c.tok_pos >= 4'd3 && f[F_MOK] && f[F_VOK]);
                                    if (!ok) w.err = ERR_START_BAD;
                                    else begin
                                        w.c.phase = PH_HEADER;
                                        w = line_start(w);
                                        ev = EV_START_OK;
                                    end
                                end
                                PH_HEADER: begin
                                    f = w.c.flags;
                                    if (w.c.line_len == 17'd0) begin
                                        if (w.c.chunked_seen) begin
                                            w.c.phase = PH_CSIZE;
                                            w = line_start(w);
                                            ev = EV_HDR_DONE;
                                        end else if (w.c.len_seen && rem_reg != '0) begin
                                            w.c.phase = PH_BODY;
                                            ev = EV_HDR_DONE;
                                        end else begin
                                            w.c.phase = PH_DONE;
                                            ev = EV_COMPLETE;
                                        end
                                    end else if (!f[F_COLON] || f[F_BAD]) begin
                                        w.err = ERR_HDR_BAD;
                                    end else if (f[7:6] == HK_LENGTH
                                                 && (f[F_INV] || !f[F_NB])) begin
                                        w.err = ERR_HDR_BAD;
                                    end else begin
                                        if (f[7:6] == HK_LENGTH && !w.c.len_seen) begin
                                            w.c.len_seen = 1'b1;
                                            rem_next = w.acc;
                                        end else if (f[7:6] == HK_CHUNKED && !f[F_INV]
                                                     && f[F_NB] && w.c.mprog == 5'd7) begin
                                            w.c.chunked_seen = 1'b1;
                                        end
                                        w = line_start(w);
                                        ev = EV_HDR_OK;
                                    end
                                end
                                PH_CSIZE: begin
                                    if (!w.c.flags[F_NB]) w.err = ERR_CHUNK_BAD;
                                    else begin
                                        if (w.acc == '0) w.c.phase = PH_TRAILER;
                                        else begin
                                            rem_next = w.acc;
                                            w.c.phase = PH_CDATA;
                                        end
                                        w = line_start(w);
                                    end
                                end
                                default: begin
                                    if (w.c.line_len == 17'd0) begin
                                        w.c.phase = PH_DONE;
                                        ev = EV_COMPLETE;
                                    end
                                    w = line_start(w);
                                end
                            endcase
                        end else begin
                            // the held CR was a lone one: it counts as content first
                            w = content(w, cfg, CH_CR);
                            if (w.err == ERR_NONE) begin
                                if (data_byte == CH_CR) w.c.flags[F_PCR] = 1'b1;
                                else w = content(w, cfg, data_byte);
                            end
                        end
                    end else if (data_byte == CH_CR) begin
                        w.c.flags[F_PCR] = 1'b1;
                    end else begin
                        w = content(w, cfg, data_byte);
                    end
                end
            endcase
        end
        if (w.err != ERR_NONE) begin
            w.c.phase = PH_ERROR;
            ev = EV_ERROR;
        end
        ctl_next = w.c;
        acc_next = w.acc;
        res.event_res = ev;
        res.error_kind = w.err;
        res.body_byte = bb;
        res.body_last = last;
        res.method_code = w.c.method;
        res.version_major = w.c.vmaj;
        res.version_minor = w.c.vmin;
        res.resp_status = w.c.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= CTL_RESET;
            acc_reg <= '0;
            rem_reg <= '0;
        end else if (accept) begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/http_message_framer.sv =====
// http_message_framer: top level, config registers, parser core and result register
// depends on hmf_pkg and hmf_core
// each accepted beat's result is registered and shown in the next cycle
// throughput: one byte per cycle (single-pass parser in hmf_core) unless a held
// result waits on m_ready; res_reg lets a new beat in while the last one is taken
// reset (aresetn low, synchronous): registers to defaults, parser to start line
module http_message_framer
    import hmf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [2:0]  m_error_kind,
    output logic [7:0]  m_body_byte,
    output logic        m_body_last,
    output logic [3:0]  m_method_code,
    output logic [7:0]  m_version_major,
    output logic [7:0]  m_version_minor,
    output logic [9:0]  m_resp_status
);

    cfg_t cfg_reg;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:      cfg_reg.response_mode <= cfg_data[0];
                REG_START_LIM: cfg_reg.start_limit <= cfg_data[15:0];
                REG_HDR_LIM:   cfg_reg.header_limit <= cfg_data;
                REG_CHUNK_LIM: cfg_reg.chunk_limit <= cfg_data[7:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    hmf_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept    (accept),
        .kind      (s_kind),
        .data_byte (s_data_byte),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) res_reg <= res;
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = res_reg.event_res;
    assign m_error_kind    = res_reg.error_kind;
    assign m_body_byte     = res_reg.body_byte;
    assign m_body_last     = res_reg.body_last;
    assign m_method_code   = res_reg.method_code;
    assign m_version_major = res_reg.version_major;
    assign m_version_minor = res_reg.version_minor;
    assign m_resp_status   = res_reg.resp_status;

endmodule
